/* hdl/v4n_pkg.sv */
// Package: widths and lane/stage types for the vector normalizer.
`default_nettype none
package v4n_pkg;
  localparam int unsigned NumLanes  = 4;
  localparam int unsigned CompW     = 16;
  localparam int unsigned MagW      = 16;
  localparam int unsigned SqW       = 32;
  localparam int unsigned SumW      = 34;
  localparam int unsigned LenW      = 17;
  localparam int unsigned UnitW     = 16;
  localparam int unsigned ThrW      = 12;
  localparam int unsigned RootSteps = 17;
  localparam int unsigned QuoBits   = 15;
  localparam int unsigned DivNumW   = MagW + QuoBits - 1;

  // per-lane element carried down the root pipe to the dividers
  typedef struct packed {
    logic            neg;
    logic [MagW-1:0] mag;
  } lane_elem_t;

  // control travelling with the item through the root pipe
  typedef struct packed {
    logic               vld;
    logic [SumW-1:0]    rem;
    logic [LenW-1:0]    root;
  } root_ctl_t;
endpackage
`default_nettype wire

/* hdl/v4n_sqlane.sv */
// One lane: sign/magnitude split and square of a component.
`default_nettype none
module v4n_sqlane (
  input  wire                          clk,
  input  wire                          en,
  input  wire signed [v4n_pkg::CompW-1:0] comp,
  output v4n_pkg::lane_elem_t          elem_r,
  output logic [v4n_pkg::SqW-1:0]      sq_r
);
  import v4n_pkg::*;
  logic [MagW-1:0] mag;
  assign mag = comp[CompW-1] ? MagW'(-{1'b0, comp}) : MagW'(comp);
  always_ff @(posedge clk) begin
    if (en) begin
      elem_r.neg <= comp[CompW-1];
      elem_r.mag <= mag;
      sq_r       <= SqW'(mag) * SqW'(mag);
    end
  end
endmodule
`default_nettype wire

/* hdl/v4n_divlane.sv */
// One lane: pipelined restoring divider, magnitude*2^14 / length, one bit a stage.
`default_nettype none
module v4n_divlane (
  input  wire                          clk,
  input  wire  [v4n_pkg::QuoBits-1:0]  en,
  input  v4n_pkg::lane_elem_t          elem,
  input  wire  [v4n_pkg::LenW-1:0]     len_q [v4n_pkg::QuoBits],
  output logic [v4n_pkg::UnitW-1:0]    unit
);
  import v4n_pkg::*;
  // remainder never exceeds the divisor, so LenW+1 bits suffice
  logic [LenW:0]        rem_r [QuoBits];
  logic [QuoBits-1:0]   quo_r [QuoBits];
  logic [DivNumW-1:0]   num_r [QuoBits];
  logic                 neg_r [QuoBits];

  always_ff @(posedge clk) begin
    for (int s = 0; s < QuoBits; s++) begin
      if (en[s]) begin
        logic [LenW+1:0] trial;
        logic [LenW:0]   rin;
        logic [QuoBits-1:0] qin;
        logic [DivNumW-1:0] nin;
        logic               ngin;
        if (s == 0) begin
          rin  = '0;
          qin  = '0;
          nin  = {elem.mag, {(QuoBits-1){1'b0}}};
          ngin = elem.neg;
          // first step takes the whole magnitude at once (quotient bit 14)
          trial = {3'b0, nin[DivNumW-1 -: MagW]} - {2'b0, len_q[s]};
        end else begin
          rin  = rem_r[s-1];
          qin  = quo_r[s-1];
          nin  = num_r[s-1];
          ngin = neg_r[s-1];
          trial = {rin, nin[DivNumW-1]} - {2'b0, len_q[s]};
        end
        if (!trial[LenW+1]) begin
          rem_r[s] <= trial[LenW:0];
          quo_r[s] <= {qin[QuoBits-2:0], 1'b1};
        end else begin
          rem_r[s] <= (s == 0) ? {2'b0, nin[DivNumW-1 -: MagW]}
                               : {rin[LenW-1:0], nin[DivNumW-1]};
          quo_r[s] <= {qin[QuoBits-2:0], 1'b0};
        end
        num_r[s] <= (s == 0) ? {nin[DivNumW-MagW-1:0], {MagW{1'b0}}}
                             : {nin[DivNumW-2:0], 1'b0};
        neg_r[s] <= ngin;
      end
    end
  end

  assign unit = neg_r[QuoBits-1] ? UnitW'(-{1'b0, quo_r[QuoBits-1]})
                                 : UnitW'(quo_r[QuoBits-1]);
endmodule
`default_nettype wire

/* hdl/vector4_normalize.sv */
// Top level: four-lane vector normalizer with pipelined root and dividers.
//
//  channel | ports                                  | direction
//  in      | in_valid/in_ready, in_comp_x..w        | sink
//  out     | out_valid/out_ready, out_unit_x..w,    | source
//          | out_vec_length, out_was_zero           |
//  cfg     | cfg_we, cfg_data (min_length)          | sink
//
// One transaction accepted per cycle while the output is not stalled. The pipe has 1 square
// stage, 1 sum stage, 17 root stages and 15 divide stages, set by the
// bit-per-stage square root and quotient pipes. Reset clears valids and
// threshold only. A stalled output freezes the entire pipe (global enable).
`default_nettype none
module vector4_normalize (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  signed [15:0] in_comp_x,
  input  wire  signed [15:0] in_comp_y,
  input  wire  signed [15:0] in_comp_z,
  input  wire  signed [15:0] in_comp_w,
  output logic        out_valid,
  input  wire         out_ready,
  output logic signed [15:0] out_unit_x,
  output logic signed [15:0] out_unit_y,
  output logic signed [15:0] out_unit_z,
  output logic signed [15:0] out_unit_w,
  output logic [16:0] out_vec_length,
  output logic        out_was_zero,
  input  wire         cfg_we,
  input  wire  [11:0] cfg_data
);
  import v4n_pkg::*;

  localparam int unsigned Depth = 2 + RootSteps + QuoBits;

  logic [ThrW-1:0] min_len_r;
  always_ff @(posedge clk) begin
    if (!rst_n) min_len_r <= '0;
    else if (cfg_we) min_len_r <= cfg_data;
  end

  // pipe advances whenever output is not stalled
  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  logic [Depth-1:0] vld_r;
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (adv) vld_r <= {vld_r[Depth-2:0], in_valid};
  end
  assign out_valid = vld_r[Depth-1];

  // stage 1: square lanes
  logic signed [CompW-1:0] comp [NumLanes];
  assign comp[0] = in_comp_x;
  assign comp[1] = in_comp_y;
  assign comp[2] = in_comp_z;
  assign comp[3] = in_comp_w;
  lane_elem_t      e1 [NumLanes];
  logic [SqW-1:0]  sq [NumLanes];
  for (genvar l = 0; l < NumLanes; l++) begin : g_sq
    v4n_sqlane u_sq (.clk(clk), .en(adv), .comp(comp[l]), .elem_r(e1[l]), .sq_r(sq[l]));
  end

  // stage 2: merge squares
  logic [SumW-1:0] sum_r;
  lane_elem_t      e2_r [NumLanes];
  always_ff @(posedge clk) begin
    if (adv) begin
      sum_r <= SumW'(sq[0]) + SumW'(sq[1]) + SumW'(sq[2]) + SumW'(sq[3]);
      for (int l = 0; l < NumLanes; l++) e2_r[l] <= e1[l];
    end
  end

  // root pipe: digit-by-digit, two radicand bits per stage
  logic [SumW-1:0] rad_r  [RootSteps];
  logic [LenW+1:0] rem_r  [RootSteps];
  logic [LenW-1:0] root_r [RootSteps];
  lane_elem_t      er_r   [RootSteps][NumLanes];
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int s = 0; s < RootSteps; s++) begin
        logic [SumW-1:0] rad;
        logic [LenW+1:0] rm;
        logic [LenW-1:0] rt;
        logic [LenW+1:0] cur;
        logic [LenW+1:0] trial;
        if (s == 0) begin
          rad = sum_r; rm = '0; rt = '0;
        end else begin
          rad = rad_r[s-1]; rm = rem_r[s-1]; rt = root_r[s-1];
        end
        cur   = {rm[LenW-1:0], rad[SumW-1 -: 2]};
        trial = cur - {rt, 2'b01};
        if (!trial[LenW+1] && cur >= {rt, 2'b01}) begin
          rem_r[s]  <= trial;
          root_r[s] <= {rt[LenW-2:0], 1'b1};
        end else begin
          rem_r[s]  <= cur;
          root_r[s] <= {rt[LenW-2:0], 1'b0};
        end
        rad_r[s] <= {rad[SumW-3:0], 2'b00};
        for (int l = 0; l < NumLanes; l++)
          er_r[s][l] <= (s == 0) ? e2_r[l] : er_r[s-1][l];
      end
    end
  end

  logic [LenW-1:0] len;
  logic            zero;
  assign len  = root_r[RootSteps-1];
  assign zero = len <= LenW'(min_len_r);

  // length/flag travel with the divide stages
  logic [LenW-1:0] len_q [QuoBits];
  logic            zero_q [QuoBits];
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int s = 0; s < QuoBits; s++) begin
        len_q[s]  <= (s == 0) ? len  : len_q[s-1];
        zero_q[s] <= (s == 0) ? zero : zero_q[s-1];
      end
    end
  end

  // divider reads its divisor one stage ahead of len_q register
  logic [LenW-1:0] dlen [QuoBits];
  always_comb begin
    dlen[0] = (len == '0) ? LenW'(1) : len;
    for (int s = 1; s < QuoBits; s++)
      dlen[s] = (len_q[s-1] == '0) ? LenW'(1) : len_q[s-1];
  end

  logic [UnitW-1:0] unit [NumLanes];
  for (genvar l = 0; l < NumLanes; l++) begin : g_div
    v4n_divlane u_div (.clk(clk), .en({QuoBits{adv}}), .elem(er_r[RootSteps-1][l]),
                       .len_q(dlen), .unit(unit[l]));
  end

  logic zf;
  assign zf = zero_q[QuoBits-1];
  assign out_unit_x     = zf ? '0 : unit[0];
  assign out_unit_y     = zf ? '0 : unit[1];
  assign out_unit_z     = zf ? '0 : unit[2];
  assign out_unit_w     = zf ? '0 : unit[3];
  assign out_vec_length = len_q[QuoBits-1];
  assign out_was_zero   = zf;

`ifndef SYNTH
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_vec_length))
    else $error("result moved during stall");
  a_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_was_zero |-> out_unit_x == 0 && out_unit_w == 0)
    else $error("zero flag with nonzero unit");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("pipe stalled while empty at output");
`endif
endmodule
`default_nettype wire
